[hw/rtl/qh_pkg.sv]
// Shared types, widths and state codes for the convex hull block.
`timescale 1ns / 1ps

package qh_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
    localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH    = PROD_WIDTH + 1;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_HULL_DEF   = 64;

    localparam logic [2:0] CLASS_NONE = 3'd4;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;

    typedef struct packed {
        coord_t x_coord;
        coord_t y_coord;
        logic   last_point;
    } qh_point_t;

    typedef struct packed {
        coord_t hull_x;
        coord_t hull_y;
        logic   last_of_run;
        logic   hull_empty;
        logic   overflow;
    } qh_vertex_t;

    typedef struct packed {
        logic   start;
        coord_t a_x;
        coord_t a_y;
        coord_t b_x;
        coord_t b_y;
        coord_t p_x;
        coord_t p_y;
    } qh_xreq_t;

    typedef struct packed {
        logic   done;
        cross_t value;
    } qh_xrsp_t;

    typedef enum logic [2:0] {
        X_IDLE,
        X_MUL1,
        X_MUL2,
        X_SUB,
        X_DONE
    } qh_xphase_t;

    typedef enum logic [1:0] {
        PASS_MAX,
        PASS_LEFT,
        PASS_RIGHT
    } qh_pass_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_EXT_RD,
        ST_EXT_CMP,
        ST_CLS_RD,
        ST_CLS_GO,
        ST_CLS_WAIT,
        ST_LBL_RD,
        ST_LBL_CHK,
        ST_PUSH,
        ST_POP,
        ST_SEG_A,
        ST_SEG_B,
        ST_SEG_CHK,
        ST_SCAN_RD,
        ST_SCAN_PT,
        ST_SCAN_GO,
        ST_SCAN_WAIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_PUSH_R,
        ST_PUSH_L,
        ST_OUT_INIT,
        ST_OUT_RD,
        ST_OUT_PT,
        ST_OUT_SEND
    } qh_state_t;

endpackage

[hw/rtl/qh_cross.sv]
// Shared cross product unit: one multiplier used twice, then a subtract.
`timescale 1ns / 1ps

module qh_cross (
    input  logic           clk,
    input  logic           rst_n,
    input  qh_pkg::qh_xreq_t req,
    output qh_pkg::qh_xrsp_t rsp
);
    import qh_pkg::*;

    qh_xphase_t ph_reg, ph_next;
    logic signed [DIFF_WIDTH-1:0] dx_reg, dy_reg, qx_reg, qy_reg;
    logic signed [DIFF_WIDTH-1:0] m_a, m_b;
    logic signed [PROD_WIDTH-1:0] mul, p1_reg, p2_reg;
    cross_t res_reg;
    logic take;

    assign take = req.start && (ph_reg == X_IDLE || ph_reg == X_DONE);

    always_comb
    begin
        ph_next = ph_reg;
        case (ph_reg)
            X_IDLE:  ph_next = take ? X_MUL1 : X_IDLE;
            X_MUL1:  ph_next = X_MUL2;
            X_MUL2:  ph_next = X_SUB;
            X_SUB:   ph_next = X_DONE;
            X_DONE:  ph_next = take ? X_MUL1 : X_IDLE;
            default: ph_next = X_IDLE;
        endcase
    end

    always_comb
    begin
        m_a = (ph_reg == X_MUL1) ? dx_reg : dy_reg;
        m_b = (ph_reg == X_MUL1) ? qy_reg : qx_reg;
        mul = m_a * m_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= X_IDLE;
        else
            ph_reg <= ph_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dx_reg <= DIFF_WIDTH'(req.b_x) - DIFF_WIDTH'(req.a_x);
            dy_reg <= DIFF_WIDTH'(req.b_y) - DIFF_WIDTH'(req.a_y);
            qx_reg <= DIFF_WIDTH'(req.p_x) - DIFF_WIDTH'(req.a_x);
            qy_reg <= DIFF_WIDTH'(req.p_y) - DIFF_WIDTH'(req.a_y);
        end
        if (ph_reg == X_MUL1)
            p1_reg <= mul;
        if (ph_reg == X_MUL2)
            p2_reg <= mul;
        if (ph_reg == X_SUB)
            res_reg <= CROSS_WIDTH'(p1_reg) - CROSS_WIDTH'(p2_reg);
    end

    assign rsp.done  = (ph_reg == X_DONE);
    assign rsp.value = res_reg;

endmodule

[hw/rtl/qh_seq.sv]
// Hull sequencer: point, label, scratch, class, stack and vertex stores.
`timescale 1ns / 1ps

module qh_seq #(
    parameter int MAX_POINTS = qh_pkg::MAX_POINTS_DEF,
    parameter int MAX_HULL   = qh_pkg::MAX_HULL_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_stall,
    input  qh_pkg::qh_point_t  point_data,
    output logic               res_valid,
    input  logic               res_take,
    output qh_pkg::qh_vertex_t res_data,
    output qh_pkg::qh_xreq_t   xreq,
    input  qh_pkg::qh_xrsp_t   xrsp
);
    import qh_pkg::*;

    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SD  = MAX_POINTS + 8;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int HAW = $clog2(MAX_HULL);
    localparam int HCW = $clog2(MAX_HULL + 1);
    localparam int SEW = 2 * IW + 2 * CW;

    localparam logic [CW-1:0]  MAXP_C = CW'(MAX_POINTS);
    localparam logic [SPW-1:0] SD_C   = SPW'(SD);
    localparam logic [HCW-1:0] HMAX_C = HCW'(MAX_HULL);

    // stores
    coord_t ptx_mem [MAX_POINTS];
    coord_t pty_mem [MAX_POINTS];
    logic [IW-1:0]  lbl_mem [MAX_POINTS];
    logic [IW-1:0]  scr_mem [MAX_POINTS];
    logic [2:0]     cls_mem [MAX_POINTS];
    logic [SEW-1:0] stk_mem [SD];
    logic [IW-1:0]  hull_mem [MAX_HULL];

    coord_t ptx_rd, pty_rd;
    logic [IW-1:0]  lbl_rd, scr_rd, hull_rd;
    logic [2:0]     cls_rd;
    logic [SEW-1:0] stk_rd;

    logic pt_we, pt_re, lbl_we, lbl_re, scr_we, scr_re, cls_we, cls_re;
    logic stk_we, stk_re, hull_we, hull_re;
    logic [IW-1:0]  pt_waddr, pt_raddr, lbl_waddr, lbl_raddr, lbl_wdata;
    logic [IW-1:0]  scr_waddr, scr_raddr, scr_wdata, cls_waddr, cls_raddr;
    logic [2:0]     cls_wdata;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [SEW-1:0] stk_wdata;
    logic [HAW-1:0] hull_waddr, hull_raddr;
    logic [IW-1:0]  hull_wdata;

    // control and working registers
    qh_state_t state_reg, state_next;
    qh_pass_t  pass_reg, pass_next;
    logic [CW-1:0]  cnt_reg, cnt_next, i_reg, i_next, k_reg, k_next, nl_reg, nl_next;
    logic [CW-1:0]  slo_reg, slo_next, shi_reg, shi_next;
    logic [CW-1:0]  bnd_reg [3];
    logic [CW-1:0]  bnd_next [3];
    logic           drop_reg, drop_next, sub_reg, sub_next, found_reg, found_next;
    logic           hovf_reg, hovf_next;
    logic [1:0]     f_reg, f_next, e_reg, e_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [HCW-1:0] hcnt_reg, hcnt_next, o_reg, o_next;
    logic [IW-1:0]  ext_idx_reg [4];
    logic [IW-1:0]  ext_idx_next [4];
    coord_t         ext_x_reg [4];
    coord_t         ext_x_next [4];
    coord_t         ext_y_reg [4];
    coord_t         ext_y_next [4];
    logic [IW-1:0]  sa_reg, sa_next, sb_reg, sb_next, best_reg, best_next, p_reg, p_next;
    coord_t         ax_reg, ax_next, ay_reg, ay_next, bx_reg, bx_next, by_reg, by_next;
    coord_t         bestx_reg, bestx_next, besty_reg, besty_next;
    cross_t         bestv_reg, bestv_next;

    logic           v_pos, v_gt, accept, push_ok, out_last;
    logic [1:0]     f_inc, e_inc;
    logic [CW-1:0]  ext_lo, ext_hi, mid, rgt, copy_addr;

    assign accept    = point_valid && !point_stall;
    assign v_pos     = !xrsp.value[CROSS_WIDTH-1] && (xrsp.value != '0);
    assign v_gt      = xrsp.value > bestv_reg;
    assign push_ok   = sp_reg < SD_C;
    assign f_inc     = f_reg + 2'd1;
    assign e_inc     = e_reg + 2'd1;
    assign ext_lo    = (e_reg == 2'd0) ? '0 : bnd_reg[e_reg - 2'd1];
    assign ext_hi    = (e_reg == 2'd3) ? k_reg : bnd_reg[e_reg];
    assign mid       = CW'(slo_reg + nl_reg);
    assign rgt       = CW'(slo_reg + k_reg);
    assign copy_addr = CW'(slo_reg + i_reg);
    assign out_last  = (hcnt_reg == '0) || (HCW'(o_reg + 1'b1) == hcnt_reg);

    assign point_stall = (state_reg != ST_LOAD);
    assign res_valid   = (state_reg == ST_OUT_SEND);

    always_comb
    begin
        res_data             = '0;
        res_data.last_of_run = out_last;
        res_data.overflow    = drop_reg || hovf_reg;
        if (hcnt_reg == '0)
            res_data.hull_empty = 1'b1;
        else
        begin
            res_data.hull_x = ptx_rd;
            res_data.hull_y = pty_rd;
        end
    end

    // operand selection for the shared unit
    always_comb
    begin
        xreq       = '0;
        xreq.p_x   = ptx_rd;
        xreq.p_y   = pty_rd;
        xreq.start = (state_reg == ST_CLS_GO) || (state_reg == ST_SCAN_GO);
        if (state_reg == ST_CLS_GO)
        begin
            xreq.a_x = ext_x_reg[f_reg];
            xreq.a_y = ext_y_reg[f_reg];
            xreq.b_x = ext_x_reg[f_inc];
            xreq.b_y = ext_y_reg[f_inc];
        end
        else if (pass_reg == PASS_MAX)
        begin
            xreq.a_x = ax_reg;
            xreq.a_y = ay_reg;
            xreq.b_x = bx_reg;
            xreq.b_y = by_reg;
        end
        else if (pass_reg == PASS_RIGHT && sub_reg)
        begin
            xreq.a_x = bestx_reg;
            xreq.a_y = besty_reg;
            xreq.b_x = bx_reg;
            xreq.b_y = by_reg;
        end
        else
        begin
            xreq.a_x = ax_reg;
            xreq.a_y = ay_reg;
            xreq.b_x = bestx_reg;
            xreq.b_y = besty_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        nl_next    = nl_reg;
        slo_next   = slo_reg;
        shi_next   = shi_reg;
        bnd_next   = bnd_reg;
        drop_next  = drop_reg;
        sub_next   = sub_reg;
        found_next = found_reg;
        hovf_next  = hovf_reg;
        f_next     = f_reg;
        e_next     = e_reg;
        sp_next    = sp_reg;
        hcnt_next  = hcnt_reg;
        o_next     = o_reg;
        ext_idx_next = ext_idx_reg;
        ext_x_next   = ext_x_reg;
        ext_y_next   = ext_y_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        best_next  = best_reg;
        p_next     = p_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        bestx_next = bestx_reg;
        besty_next = besty_reg;
        bestv_next = bestv_reg;

        pt_we = 1'b0; pt_re = 1'b0; pt_waddr = cnt_reg[IW-1:0]; pt_raddr = i_reg[IW-1:0];
        lbl_we = 1'b0; lbl_re = 1'b0; lbl_waddr = k_reg[IW-1:0]; lbl_wdata = i_reg[IW-1:0];
        lbl_raddr = i_reg[IW-1:0];
        scr_we = 1'b0; scr_re = 1'b0; scr_waddr = k_reg[IW-1:0]; scr_wdata = p_reg;
        scr_raddr = i_reg[IW-1:0];
        cls_we = 1'b0; cls_re = 1'b0; cls_waddr = i_reg[IW-1:0]; cls_wdata = {1'b0, f_reg};
        cls_raddr = i_reg[IW-1:0];
        stk_we = 1'b0; stk_re = 1'b0; stk_waddr = sp_reg[SAW-1:0];
        stk_raddr = SAW'(sp_reg - 1'b1);
        stk_wdata = {ext_idx_reg[e_reg], ext_idx_reg[e_inc], ext_lo, ext_hi};
        hull_we = 1'b0; hull_re = 1'b0; hull_waddr = hcnt_reg[HAW-1:0]; hull_wdata = sb_reg;
        hull_raddr = o_reg[HAW-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (cnt_reg < MAXP_C)
                    begin
                        pt_we    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                        drop_next = 1'b1;
                    if (point_data.last_point)
                    begin
                        i_next     = '0;
                        hcnt_next  = '0;
                        hovf_next  = 1'b0;
                        sp_next    = '0;
                        state_next = ST_EXT_RD;
                    end
                end
            end
            ST_EXT_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    i_next     = '0;
                    state_next = ST_CLS_RD;
                end
                else
                begin
                    pt_re      = 1'b1;
                    state_next = ST_EXT_CMP;
                end
            end
            ST_EXT_CMP:
            begin
                // strict compares: the earliest point keeps a tie
                if (i_reg == '0)
                begin
                    for (int n = 0; n < 4; n++)
                    begin
                        ext_idx_next[n] = '0;
                        ext_x_next[n]   = ptx_rd;
                        ext_y_next[n]   = pty_rd;
                    end
                end
                else
                begin
                    if (ptx_rd < ext_x_reg[0])
                    begin
                        ext_idx_next[0] = i_reg[IW-1:0];
                        ext_x_next[0]   = ptx_rd;
                        ext_y_next[0]   = pty_rd;
                    end
                    if (pty_rd > ext_y_reg[1])
                    begin
                        ext_idx_next[1] = i_reg[IW-1:0];
                        ext_x_next[1]   = ptx_rd;
                        ext_y_next[1]   = pty_rd;
                    end
                    if (ptx_rd > ext_x_reg[2])
                    begin
                        ext_idx_next[2] = i_reg[IW-1:0];
                        ext_x_next[2]   = ptx_rd;
                        ext_y_next[2]   = pty_rd;
                    end
                    if (pty_rd < ext_y_reg[3])
                    begin
                        ext_idx_next[3] = i_reg[IW-1:0];
                        ext_x_next[3]   = ptx_rd;
                        ext_y_next[3]   = pty_rd;
                    end
                end
                i_next     = i_reg + 1'b1;
                state_next = ST_EXT_RD;
            end
            ST_CLS_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    i_next     = '0;
                    k_next     = '0;
                    e_next     = '0;
                    state_next = ST_LBL_RD;
                end
                else
                begin
                    pt_re      = 1'b1;
                    f_next     = '0;
                    state_next = ST_CLS_GO;
                end
            end
            ST_CLS_GO:
            begin
                state_next = ST_CLS_WAIT;
            end
            ST_CLS_WAIT:
            begin
                if (xrsp.done)
                begin
                    if (v_pos || f_reg == 2'd3)
                    begin
                        cls_we     = 1'b1;
                        cls_wdata  = v_pos ? {1'b0, f_reg} : CLASS_NONE;
                        i_next     = i_reg + 1'b1;
                        state_next = ST_CLS_RD;
                    end
                    else
                    begin
                        f_next     = f_inc;
                        state_next = ST_CLS_GO;
                    end
                end
            end
            ST_LBL_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    if (e_reg == 2'd3)
                        state_next = ST_PUSH;
                    else
                    begin
                        bnd_next[e_reg] = k_reg;
                        e_next          = e_inc;
                        i_next          = '0;
                    end
                end
                else
                begin
                    cls_re     = 1'b1;
                    state_next = ST_LBL_CHK;
                end
            end
            ST_LBL_CHK:
            begin
                if (cls_rd == {1'b0, e_reg})
                begin
                    lbl_we = 1'b1;
                    k_next = k_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = ST_LBL_RD;
            end
            ST_PUSH:
            begin
                // push the four outer edges, last edge first
                if (push_ok)
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                if (e_reg == 2'd0)
                    state_next = ST_POP;
                else
                    e_next = e_reg - 2'd1;
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                    state_next = ST_OUT_INIT;
                else
                begin
                    stk_re     = 1'b1;
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_SEG_A;
                end
            end
            ST_SEG_A:
            begin
                sa_next    = stk_rd[SEW-1 -: IW];
                sb_next    = stk_rd[SEW-IW-1 -: IW];
                slo_next   = stk_rd[2*CW-1 -: CW];
                shi_next   = stk_rd[CW-1:0];
                pt_re      = 1'b1;
                pt_raddr   = stk_rd[SEW-1 -: IW];
                state_next = ST_SEG_B;
            end
            ST_SEG_B:
            begin
                ax_next    = ptx_rd;
                ay_next    = pty_rd;
                pt_re      = 1'b1;
                pt_raddr   = sb_reg;
                state_next = ST_SEG_CHK;
            end
            ST_SEG_CHK:
            begin
                bx_next = ptx_rd;
                by_next = pty_rd;
                // drop a segment whose ends coincide
                if (ptx_rd == ax_reg && pty_rd == ay_reg)
                    state_next = ST_POP;
                else
                begin
                    i_next     = slo_reg;
                    found_next = 1'b0;
                    bestv_next = '0;
                    pass_next  = PASS_MAX;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (i_reg == shi_reg)
                begin
                    case (pass_reg)
                        PASS_MAX:
                        begin
                            if (!found_reg)
                            begin
                                if (hcnt_reg < HMAX_C)
                                begin
                                    hull_we   = 1'b1;
                                    hcnt_next = hcnt_reg + 1'b1;
                                end
                                else
                                    hovf_next = 1'b1;
                                state_next = ST_POP;
                            end
                            else
                            begin
                                pass_next = PASS_LEFT;
                                i_next    = slo_reg;
                                k_next    = '0;
                            end
                        end
                        PASS_LEFT:
                        begin
                            nl_next   = k_reg;
                            pass_next = PASS_RIGHT;
                            i_next    = slo_reg;
                        end
                        default:
                        begin
                            i_next     = '0;
                            state_next = ST_COPY_RD;
                        end
                    endcase
                end
                else
                begin
                    lbl_re     = 1'b1;
                    state_next = ST_SCAN_PT;
                end
            end
            ST_SCAN_PT:
            begin
                p_next     = lbl_rd;
                pt_re      = 1'b1;
                pt_raddr   = lbl_rd;
                sub_next   = 1'b0;
                state_next = ST_SCAN_GO;
            end
            ST_SCAN_GO:
            begin
                state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (xrsp.done)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                    case (pass_reg)
                        PASS_MAX:
                        begin
                            if (v_gt)
                            begin
                                bestv_next = xrsp.value;
                                best_next  = p_reg;
                                bestx_next = ptx_rd;
                                besty_next = pty_rd;
                                found_next = 1'b1;
                            end
                        end
                        PASS_LEFT:
                        begin
                            if (v_pos)
                            begin
                                scr_we = 1'b1;
                                k_next = k_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!sub_reg)
                            begin
                                // not left of a->best: try best->b
                                if (!v_pos)
                                begin
                                    sub_next   = 1'b1;
                                    i_next     = i_reg;
                                    state_next = ST_SCAN_GO;
                                end
                            end
                            else if (v_pos)
                            begin
                                scr_we = 1'b1;
                                k_next = k_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_COPY_RD:
            begin
                if (i_reg == k_reg)
                    state_next = ST_PUSH_R;
                else
                begin
                    scr_re     = 1'b1;
                    state_next = ST_COPY_WR;
                end
            end
            ST_COPY_WR:
            begin
                lbl_we     = 1'b1;
                lbl_waddr  = copy_addr[IW-1:0];
                lbl_wdata  = scr_rd;
                i_next     = i_reg + 1'b1;
                state_next = ST_COPY_RD;
            end
            ST_PUSH_R:
            begin
                stk_wdata = {best_reg, sb_reg, mid, rgt};
                if (push_ok)
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                state_next = ST_PUSH_L;
            end
            ST_PUSH_L:
            begin
                stk_wdata = {sa_reg, best_reg, slo_reg, mid};
                if (push_ok)
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + 1'b1;
                end
                state_next = ST_POP;
            end
            ST_OUT_INIT:
            begin
                o_next     = '0;
                state_next = (hcnt_reg == '0) ? ST_OUT_SEND : ST_OUT_RD;
            end
            ST_OUT_RD:
            begin
                hull_re    = 1'b1;
                state_next = ST_OUT_PT;
            end
            ST_OUT_PT:
            begin
                pt_re      = 1'b1;
                pt_raddr   = hull_rd;
                state_next = ST_OUT_SEND;
            end
            ST_OUT_SEND:
            begin
                if (res_take)
                begin
                    if (out_last)
                    begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        o_next     = o_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            pass_reg  <= PASS_MAX;
            cnt_reg   <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            nl_reg    <= '0;
            drop_reg  <= 1'b0;
            sub_reg   <= 1'b0;
            found_reg <= 1'b0;
            hovf_reg  <= 1'b0;
            f_reg     <= '0;
            e_reg     <= '0;
            sp_reg    <= '0;
            hcnt_reg  <= '0;
            o_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            nl_reg    <= nl_next;
            drop_reg  <= drop_next;
            sub_reg   <= sub_next;
            found_reg <= found_next;
            hovf_reg  <= hovf_next;
            f_reg     <= f_next;
            e_reg     <= e_next;
            sp_reg    <= sp_next;
            hcnt_reg  <= hcnt_next;
            o_reg     <= o_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slo_reg     <= slo_next;
        shi_reg     <= shi_next;
        bnd_reg     <= bnd_next;
        ext_idx_reg <= ext_idx_next;
        ext_x_reg   <= ext_x_next;
        ext_y_reg   <= ext_y_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        best_reg    <= best_next;
        p_reg       <= p_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        bestx_reg   <= bestx_next;
        besty_reg   <= besty_next;
        bestv_reg   <= bestv_next;
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            ptx_mem[pt_waddr] <= point_data.x_coord;
            pty_mem[pt_waddr] <= point_data.y_coord;
        end
        if (pt_re)
        begin
            ptx_rd <= ptx_mem[pt_raddr];
            pty_rd <= pty_mem[pt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lbl_we)
            lbl_mem[lbl_waddr] <= lbl_wdata;
        if (lbl_re)
            lbl_rd <= lbl_mem[lbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[scr_waddr] <= scr_wdata;
        if (scr_re)
            scr_rd <= scr_mem[scr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cls_we)
            cls_mem[cls_waddr] <= cls_wdata;
        if (cls_re)
            cls_rd <= cls_mem[cls_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rd <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hull_we)
            hull_mem[hull_waddr] <= hull_wdata;
        if (hull_re)
            hull_rd <= hull_mem[hull_raddr];
    end

endmodule

[hw/rtl/quickhull_2d_convex_hull.sv]
// A point request is taken every cycle while loading, with no result.
// After the request flagged last the input stalls for the hull run: extremes are
// found, points are classified with up to 4 cross products each in the shared unit,
// grouped by edge, then refined with 1 to 2 cross products per point per pass,
// and the vertices go out. Vertex results leave through one output register.
// Reset is asynchronous active low and clears control state; stores are not cleared.
`timescale 1ns / 1ps

module quickhull_2d_convex_hull #(
    parameter int MAX_POINTS = qh_pkg::MAX_POINTS_DEF,
    parameter int MAX_HULL   = qh_pkg::MAX_HULL_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_stall,
    input  qh_pkg::qh_point_t  point_data,
    output logic               vertex_valid,
    input  logic               vertex_stall,
    output qh_pkg::qh_vertex_t vertex_data
);
    import qh_pkg::*;

    qh_xreq_t   xreq;
    qh_xrsp_t   xrsp;
    qh_vertex_t res_data, vtx_reg;
    logic       res_valid, res_take, vtx_valid_reg;

    qh_cross u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (xreq),
        .rsp   (xrsp)
    );

    qh_seq #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_HULL   (MAX_HULL)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_data  (point_data),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res_data    (res_data),
        .xreq        (xreq),
        .xrsp        (xrsp)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!vtx_valid_reg || !vertex_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vtx_valid_reg <= 1'b0;
        else if (res_take)
            vtx_valid_reg <= 1'b1;
        else if (!vertex_stall)
            vtx_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            vtx_reg <= res_data;
    end

    assign vertex_valid = vtx_valid_reg;
    assign vertex_data  = vtx_reg;

    a_busy_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> point_stall)
        else $error("result offered while loading points");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_data.hull_empty |->
            vertex_data.last_of_run && vertex_data.hull_x == 0 && vertex_data.hull_y == 0)
        else $error("empty hull result malformed");

    a_cross_latency: assert property (@(posedge clk) disable iff (!rst_n)
        xreq.start |=> !xrsp.done)
        else $error("cross product done too early");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> vertex_valid)
        else $error("taken result not presented");

endmodule
